[rtl/core/tlps_pkg.sv]
// Shared types, constants and widths of the tank level plant model.
package tlps_pkg;

  localparam int LEVEL_W    = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int TICK_W     = 10;
  localparam int CMD_W      = 18;
  localparam int CMDQ_W     = 17;
  localparam int FILL_W     = 17;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 48;

  // 19.64 in Q16
  localparam int K_W = 21;
  localparam logic [K_W-1:0] K_TORRICELLI = 21'd1287127;

  localparam logic [CMDQ_W-1:0] ONE_Q16 = 17'd65536;

  // serial unit widths
  localparam int OPA_W     = 35;
  localparam int MPL_W     = 24;
  localparam int PROD_W    = 49;
  localparam int CNT_W     = 6;
  localparam int DREM_W    = 10;
  localparam int RAD_W     = 46;
  localparam int SQRT_FRAC = 16;
  localparam int ROOT_W    = 23;
  localparam int SREM_W    = 24;
  localparam logic [DREM_W:0] DIVISOR = 11'd1000;

  // steps per operation
  localparam logic [CNT_W-1:0] N_K    = CNT_W'(K_W);
  localparam logic [CNT_W-1:0] N_SQRT = CNT_W'(ROOT_W);
  localparam logic [CNT_W-1:0] N_V    = CNT_W'(ROOT_W);
  localparam logic [CNT_W-1:0] N_TICK = CNT_W'(TICK_W);
  localparam logic [CNT_W-1:0] N_DIV  = CNT_W'(OPA_W);
  localparam logic [CNT_W-1:0] N_CMD  = CNT_W'(CMDQ_W);
  localparam logic [CNT_W-1:0] N_Q24  = CNT_W'(MPL_W);

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0]  RST_HEIGHT     = 24'd65536;
  localparam logic [CFG_W-1:0]  RST_INV_HEIGHT = 24'd65536;
  localparam logic [CFG_W-1:0]  RST_INV_AREA   = 24'd65536;
  localparam logic [CFG_W-1:0]  RST_OUTLET     = 24'd16777;
  localparam logic [CFG_W-1:0]  RST_PUMP       = 24'd167772;
  localparam logic [TICK_W-1:0] RST_TICK       = 10'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HEIGHT     = 3'd0,
    CFG_INV_HEIGHT = 3'd1,
    CFG_INV_AREA   = 3'd2,
    CFG_OUTLET     = 3'd3,
    CFG_PUMP       = 3'd4,
    CFG_TICK       = 3'd5
  } tlps_cfg_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } tlps_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XMUL,
    S_SQRT,
    S_OAMUL,
    S_TK1,
    S_DIV1,
    S_PMUL,
    S_TK2,
    S_DIV2,
    S_INC,
    S_FILL,
    S_PUSH
  } tlps_state_t;

  typedef struct packed {
    logic             start;
    tlps_op_t         op;
    logic [OPA_W-1:0] opa;
    logic [MPL_W-1:0] opb;
    logic [CNT_W-1:0] count;
  } tlps_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] res;
  } tlps_rsp_t;

endpackage

[rtl/core/tank_level_plant_step.sv]
// Top level of the fixed-point pumped tank plant model.
//
// Input stream (s_*): one beat is either a tick (s_tuser = 0) carrying the
// pump command, or a level load (s_tuser = 1) carrying the new level.
// Output stream (m_*): one beat per input beat with the level after the beat,
// the fill ratio and the overflow / load-rejected flags.
// Config port: cfg_we writes cfg_data into register cfg_addr;
// write only while no beat is in flight.
// One beat is worked on at a time; s_tready is high only when idle.
// A tick runs ten bit-serial operations on one shared unit (x = 19.64*level,
// square root, outlet*v, *tick_ms, /1000, pump*cmd, *tick_ms, /1000,
// *inv_base_area, fill ratio), then the push state loads the output
// register and raises m_tvalid. A load runs only the fill ratio.
// The result sits in an output register, so a new beat is accepted while it
// waits; if the receiver stalls long enough the next result waits in the
// push state and s_tready stays low until the output register frees.
// Reset (rst, synchronous) sets the registers to their defaults, the level
// to zero and empties the output register.
module tank_level_plant_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tlps_pkg::IN_W-1:0]       s_tdata,  // pump_command[17:0], new_level[41:18]
  input  logic                            s_tuser,  // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tlps_pkg::OUT_W-1:0]      m_tdata,  // level[23:0], fill_ratio[40:24],
                                                    // overflowed[41], load_rejected[42]
  input  logic                            cfg_we,
  input  logic [tlps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlps_pkg::CFG_W-1:0]      cfg_data
);

  logic [tlps_pkg::CFG_W-1:0]   tank_height;
  logic [tlps_pkg::CFG_W-1:0]   inv_tank_height;
  logic [tlps_pkg::CFG_W-1:0]   inv_base_area;
  logic [tlps_pkg::CFG_W-1:0]   outlet_area;
  logic [tlps_pkg::CFG_W-1:0]   pump_max_flow;
  logic [tlps_pkg::TICK_W-1:0]  tick_ms;

  tlps_pkg::tlps_state_t        state;
  tlps_pkg::tlps_state_t        state_next;
  logic                         issue;
  logic                         issue_next;

  logic [tlps_pkg::LEVEL_W-1:0] water_level;
  logic [tlps_pkg::LEVEL_W-1:0] lvl_work;
  logic [tlps_pkg::OPA_W-1:0]   arg;
  logic [tlps_pkg::CMDQ_W-1:0]  cmd;
  logic [tlps_pkg::FILL_W-1:0]  fill_val;
  logic                         ovf;
  logic                         rej;

  logic [tlps_pkg::LEVEL_W-1:0] out_level;
  logic [tlps_pkg::FILL_W-1:0]  out_fill;
  logic                         out_ovf;
  logic                         out_rej;

  tlps_pkg::tlps_req_t          req;
  tlps_pkg::tlps_rsp_t          rsp;

  logic                         accept;
  logic [tlps_pkg::CMD_W-1:0]   raw_cmd;
  logic [tlps_pkg::CMDQ_W-1:0]  cmd_clamped;
  logic [tlps_pkg::LEVEL_W-1:0] new_level;
  logic                         load_ok;
  logic [tlps_pkg::LEVEL_W+1:0] inc_sum;
  logic [31:0]                  fill_hi;

  assign s_tready = (state == tlps_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign raw_cmd     = s_tdata[tlps_pkg::CMD_W-1:0];
  assign new_level   = s_tdata[tlps_pkg::CMD_W +: tlps_pkg::LEVEL_W];
  assign cmd_clamped = raw_cmd[tlps_pkg::CMD_W-1] ? '0 :
                       (raw_cmd[tlps_pkg::CMDQ_W-1:0] > tlps_pkg::ONE_Q16) ?
                       tlps_pkg::ONE_Q16 : raw_cmd[tlps_pkg::CMDQ_W-1:0];
  assign load_ok     = (new_level != '0) && (new_level < tank_height);

  // level after drain plus inflow increment (product bits 48:24)
  assign inc_sum = {2'b00, lvl_work} + {1'b0, rsp.res[48:24]};
  assign fill_hi = rsp.res[47:16];

  tlps_serial_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlps_pkg::S_IDLE;
      issue <= 1'b0;
    end else begin
      state <= state_next;
      issue <= issue_next;
    end
  end

  always_comb begin
    state_next = state;
    req        = '0;
    req.start  = issue;
    req.op     = tlps_pkg::OP_MUL;
    case (state)
      tlps_pkg::S_IDLE: begin
        if (accept) state_next = s_tuser ? tlps_pkg::S_FILL : tlps_pkg::S_XMUL;
      end
      tlps_pkg::S_XMUL: begin
        req.opa   = {{(tlps_pkg::OPA_W-tlps_pkg::LEVEL_W){1'b0}}, water_level};
        req.opb   = {{(tlps_pkg::MPL_W-tlps_pkg::K_W){1'b0}}, tlps_pkg::K_TORRICELLI};
        req.count = tlps_pkg::N_K;
        if (rsp.done) state_next = tlps_pkg::S_SQRT;
      end
      tlps_pkg::S_SQRT: begin
        req.op    = tlps_pkg::OP_SQRT;
        req.opa   = arg;
        req.count = tlps_pkg::N_SQRT;
        if (rsp.done) state_next = tlps_pkg::S_OAMUL;
      end
      tlps_pkg::S_OAMUL: begin
        req.opa   = {{(tlps_pkg::OPA_W-tlps_pkg::CFG_W){1'b0}}, outlet_area};
        req.opb   = arg[tlps_pkg::MPL_W-1:0];
        req.count = tlps_pkg::N_V;
        if (rsp.done) state_next = tlps_pkg::S_TK1;
      end
      tlps_pkg::S_TK1: begin
        req.opa   = arg;
        req.opb   = {{(tlps_pkg::MPL_W-tlps_pkg::TICK_W){1'b0}}, tick_ms};
        req.count = tlps_pkg::N_TICK;
        if (rsp.done) state_next = tlps_pkg::S_DIV1;
      end
      tlps_pkg::S_DIV1: begin
        req.op    = tlps_pkg::OP_DIV;
        req.opa   = arg;
        req.count = tlps_pkg::N_DIV;
        if (rsp.done) state_next = tlps_pkg::S_PMUL;
      end
      tlps_pkg::S_PMUL: begin
        req.opa   = {{(tlps_pkg::OPA_W-tlps_pkg::CFG_W){1'b0}}, pump_max_flow};
        req.opb   = {{(tlps_pkg::MPL_W-tlps_pkg::CMDQ_W){1'b0}}, cmd};
        req.count = tlps_pkg::N_CMD;
        if (rsp.done) state_next = tlps_pkg::S_TK2;
      end
      tlps_pkg::S_TK2: begin
        req.opa   = arg;
        req.opb   = {{(tlps_pkg::MPL_W-tlps_pkg::TICK_W){1'b0}}, tick_ms};
        req.count = tlps_pkg::N_TICK;
        if (rsp.done) state_next = tlps_pkg::S_DIV2;
      end
      tlps_pkg::S_DIV2: begin
        req.op    = tlps_pkg::OP_DIV;
        req.opa   = arg;
        req.count = tlps_pkg::N_DIV;
        if (rsp.done) state_next = tlps_pkg::S_INC;
      end
      tlps_pkg::S_INC: begin
        req.opa   = arg;
        req.opb   = inv_base_area;
        req.count = tlps_pkg::N_Q24;
        if (rsp.done) state_next = tlps_pkg::S_FILL;
      end
      tlps_pkg::S_FILL: begin
        req.opa   = {{(tlps_pkg::OPA_W-tlps_pkg::LEVEL_W){1'b0}}, water_level};
        req.opb   = inv_tank_height;
        req.count = tlps_pkg::N_Q24;
        if (rsp.done) state_next = tlps_pkg::S_PUSH;
      end
      tlps_pkg::S_PUSH: begin
        if (!m_tvalid || m_tready) state_next = tlps_pkg::S_IDLE;
      end
      default: state_next = tlps_pkg::S_IDLE;
    endcase
    // kick the unit in the first cycle of every arithmetic state
    issue_next = (state_next != state) && (state_next != tlps_pkg::S_IDLE) &&
                 (state_next != tlps_pkg::S_PUSH);
  end

  // configuration, level state and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tank_height     <= tlps_pkg::RST_HEIGHT;
      inv_tank_height <= tlps_pkg::RST_INV_HEIGHT;
      inv_base_area   <= tlps_pkg::RST_INV_AREA;
      outlet_area     <= tlps_pkg::RST_OUTLET;
      pump_max_flow   <= tlps_pkg::RST_PUMP;
      tick_ms         <= tlps_pkg::RST_TICK;
      water_level     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          tlps_pkg::CFG_HEIGHT:     tank_height     <= cfg_data;
          tlps_pkg::CFG_INV_HEIGHT: inv_tank_height <= cfg_data;
          tlps_pkg::CFG_INV_AREA:   inv_base_area   <= cfg_data;
          tlps_pkg::CFG_OUTLET:     outlet_area     <= cfg_data;
          tlps_pkg::CFG_PUMP:       pump_max_flow   <= cfg_data;
          tlps_pkg::CFG_TICK:       tick_ms         <= cfg_data[tlps_pkg::TICK_W-1:0];
          default: begin
          end
        endcase
      end

      if (accept && s_tuser && load_ok) water_level <= new_level;

      // ceiling is the height, which always fits the level width
      if (state == tlps_pkg::S_INC && rsp.done) begin
        if (inc_sum > {2'b00, tank_height}) water_level <= tank_height;
        else                                water_level <= inc_sum[tlps_pkg::LEVEL_W-1:0];
      end

      if (state == tlps_pkg::S_PUSH && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready)                                        m_tvalid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_clamped;
      ovf <= 1'b0;
      rej <= s_tuser && !load_ok;
    end
    if (rsp.done) begin
      case (state)
        tlps_pkg::S_XMUL:  arg <= {6'd0, rsp.res[44:16]};   // x = level*19.64
        tlps_pkg::S_SQRT:  arg <= rsp.res[tlps_pkg::OPA_W-1:0];
        tlps_pkg::S_OAMUL: arg <= {2'd0, rsp.res[46:14]};
        // floor(floor(p/1000)/1024) == floor(floor(p/1024)/1000)
        tlps_pkg::S_TK1:   arg <= {2'd0, rsp.res[42:10]};
        tlps_pkg::S_DIV1: begin
          if (rsp.res[tlps_pkg::OPA_W-1:0] >
              {{(tlps_pkg::OPA_W-tlps_pkg::LEVEL_W){1'b0}}, water_level})
            lvl_work <= '0;
          else
            lvl_work <= water_level - rsp.res[tlps_pkg::LEVEL_W-1:0];
        end
        tlps_pkg::S_PMUL:  arg <= {10'd0, rsp.res[40:16]};
        tlps_pkg::S_TK2:   arg <= rsp.res[tlps_pkg::OPA_W-1:0];
        tlps_pkg::S_DIV2:  arg <= rsp.res[tlps_pkg::OPA_W-1:0];
        tlps_pkg::S_INC:   ovf <= inc_sum > {2'b00, tank_height};
        tlps_pkg::S_FILL: begin
          if (fill_hi > {15'd0, tlps_pkg::ONE_Q16}) fill_val <= tlps_pkg::ONE_Q16;
          else                                      fill_val <= fill_hi[tlps_pkg::FILL_W-1:0];
        end
        default: begin
        end
      endcase
    end
    if (state == tlps_pkg::S_PUSH && (!m_tvalid || m_tready)) begin
      out_level <= water_level;
      out_fill  <= fill_val;
      out_ovf   <= ovf;
      out_rej   <= rej;
    end
  end

  assign m_tdata = {5'd0, out_rej, out_ovf, out_fill, out_level};

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state != tlps_pkg::S_IDLE)
    else $error("accepted beat did not start work");

  a_done_in_op: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state != tlps_pkg::S_IDLE && state != tlps_pkg::S_PUSH))
    else $error("serial unit finished outside an arithmetic state");

  a_out_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == tlps_pkg::S_PUSH)
    else $error("output beat raised outside the push state");

  a_level_ceiling: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == tlps_pkg::S_INC && $past(rsp.done)) |-> water_level <= tank_height)
    else $error("tick left the level above the tank height");
`endif

endmodule

[rtl/core/tlps_serial_unit.sv]
// Bit-serial arithmetic unit: shift-add multiply, divide by 1000, square root.
module tlps_serial_unit (
  input  logic                clk,
  input  logic                rst,
  input  tlps_pkg::tlps_req_t req,
  output tlps_pkg::tlps_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [tlps_pkg::CNT_W-1:0]     cnt;
  tlps_pkg::tlps_op_t             op;

  logic [tlps_pkg::PROD_W-1:0]    acc;
  logic [tlps_pkg::PROD_W-1:0]    mcand;
  logic [tlps_pkg::MPL_W-1:0]     mpl;

  logic [tlps_pkg::OPA_W-1:0]     dq;
  logic [tlps_pkg::DREM_W-1:0]    drem;

  logic [tlps_pkg::RAD_W-1:0]     rad;
  logic [tlps_pkg::SREM_W-1:0]    srem;
  logic [tlps_pkg::ROOT_W-1:0]    root;

  logic [tlps_pkg::DREM_W:0]      dtrial;
  logic [tlps_pkg::DREM_W:0]      dsub;
  logic                           dge;
  logic [tlps_pkg::SREM_W+1:0]    srem_sh;
  logic [tlps_pkg::SREM_W+1:0]    strial;
  logic [tlps_pkg::SREM_W+1:0]    ssub;
  logic                           sge;
  logic [tlps_pkg::PROD_W-1:0]    res;

  // restoring divide step: remainder pulls in the next dividend bit
  assign dtrial = {drem, dq[tlps_pkg::OPA_W-1]};
  assign dge    = dtrial >= tlps_pkg::DIVISOR;
  assign dsub   = dtrial - tlps_pkg::DIVISOR;

  // restoring square root step, one radicand bit pair per cycle
  assign srem_sh = {srem, rad[tlps_pkg::RAD_W-1 -: 2]};
  assign strial  = {1'b0, root, 2'b01};
  assign sge     = srem_sh >= strial;
  assign ssub    = srem_sh - strial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == {{(tlps_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op    <= req.op;
      acc   <= '0;
      mcand <= {{(tlps_pkg::PROD_W-tlps_pkg::OPA_W){1'b0}}, req.opa};
      mpl   <= req.opb;
      dq    <= req.opa;
      drem  <= '0;
      rad   <= {req.opa[tlps_pkg::RAD_W-tlps_pkg::SQRT_FRAC-1:0],
                {tlps_pkg::SQRT_FRAC{1'b0}}};
      srem  <= '0;
      root  <= '0;
    end else if (busy) begin
      case (op)
        tlps_pkg::OP_MUL: begin
          acc   <= acc + (mpl[0] ? mcand : '0);
          mcand <= {mcand[tlps_pkg::PROD_W-2:0], 1'b0};
          mpl   <= {1'b0, mpl[tlps_pkg::MPL_W-1:1]};
        end
        tlps_pkg::OP_DIV: begin
          drem <= dge ? dsub[tlps_pkg::DREM_W-1:0] : dtrial[tlps_pkg::DREM_W-1:0];
          dq   <= {dq[tlps_pkg::OPA_W-2:0], dge};
        end
        tlps_pkg::OP_SQRT: begin
          rad  <= {rad[tlps_pkg::RAD_W-3:0], 2'b00};
          srem <= sge ? ssub[tlps_pkg::SREM_W-1:0] : srem_sh[tlps_pkg::SREM_W-1:0];
          root <= {root[tlps_pkg::ROOT_W-2:0], sge};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (op)
      tlps_pkg::OP_MUL:  res = acc;
      tlps_pkg::OP_DIV:  res = {{(tlps_pkg::PROD_W-tlps_pkg::OPA_W){1'b0}}, dq};
      tlps_pkg::OP_SQRT: res = {{(tlps_pkg::PROD_W-tlps_pkg::ROOT_W){1'b0}}, root};
      default:           res = '0;
    endcase
  end

  assign rsp.done = done;
  assign rsp.res  = res;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("serial unit started while busy");

  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("serial unit busy with zero step count");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("serial unit done without a finished run");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking stream testbench for the pumped tank level plant model.
module testbench;
  import tlps_pkg::*;

  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [FILL_W-1:0]  fill;
    logic               ovf;
    logic               rej;
  } plant_out_t;

  // Tracks the plant state and registers, predicts each beat, checks outputs.
  class plant_checker;
    longint unsigned height, inv_height, inv_area, outlet, pump, tick_ms;
    longint unsigned level;
    int errors;
    plant_out_t level_q[$];

    function new();
      height     = RST_HEIGHT;
      inv_height = RST_INV_HEIGHT;
      inv_area   = RST_INV_AREA;
      outlet     = RST_OUTLET;
      pump       = RST_PUMP;
      tick_ms    = RST_TICK;
      level      = 0;
      errors     = 0;
    endfunction

    function void set_reg(tlps_cfg_t idx, longint unsigned v);
      case (idx)
        CFG_HEIGHT:     height = v & 24'hFFFFFF;
        CFG_INV_HEIGHT: inv_height = v & 24'hFFFFFF;
        CFG_INV_AREA:   inv_area = v & 24'hFFFFFF;
        CFG_OUTLET:     outlet = v & 24'hFFFFFF;
        CFG_PUMP:       pump = v & 24'hFFFFFF;
        CFG_TICK:       tick_ms = v & 10'h3FF;
        default: ;
      endcase
    endfunction

    function int pending();
      return level_q.size();
    endfunction

    // floor(sqrt(x * 2^16)), two radicand bits per step
    function longint unsigned root_q16(longint unsigned x);
      longint unsigned rem, root, pair, trial;
      int i;
      rem = 0;
      root = 0;
      for (i = 35; i >= 0; i--) begin
        pair = 0;
        if (2 * i >= 16) pair = (x >> (2 * i - 16)) & 64'd3;
        rem = (rem << 2) | pair;
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function void note_beat(logic load, logic [CMD_W-1:0] cmd_raw, logic [LEVEL_W-1:0] nl);
      longint unsigned lvl, cmd, x, v, drain, a, b, inc, fr;
      plant_out_t r;
      r = '0;
      lvl = level;
      if (load) begin
        if (nl != 0 && nl < height) lvl = nl;
        else r.rej = 1'b1;
      end else begin
        if (cmd_raw[CMD_W-1]) cmd = 0;
        else if (cmd_raw > ONE_Q16) cmd = ONE_Q16;
        else cmd = cmd_raw;
        x = (lvl >> 16) * K_TORRICELLI + (((lvl & 64'hFFFF) * K_TORRICELLI) >> 16);
        v = root_q16(x);
        drain = ((((outlet * v) >> 14) * tick_ms) / 1000) >> 10;
        lvl = (drain > lvl) ? 0 : lvl - drain;
        a = (pump * cmd) >> 16;
        b = (a * tick_ms) / 1000;
        inc = (b * inv_area) >> 24;
        lvl = lvl + inc;
        // height register is no wider than the level, so it is the ceiling
        if (lvl > height) begin
          lvl = height;
          r.ovf = 1'b1;
        end
      end
      level = lvl & 64'hFFFFFF;
      if (inv_height == 0) fr = 0;
      else fr = (level * inv_height) >> 16;
      if (fr > ONE_Q16) fr = ONE_Q16;
      r.level = level[LEVEL_W-1:0];
      r.fill = fr[FILL_W-1:0];
      level_q.push_back(r);
    endfunction

    function void compare(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t %s: expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_beat(logic [OUT_W-1:0] d);
      plant_out_t e;
      if (level_q.size() == 0) begin
        errors++;
        $display("%0t output beat with nothing pending: expected none, actual %h", $time, d);
        return;
      end
      e = level_q.pop_front();
      compare("level", e.level, d[23:0]);
      compare("fill_ratio", e.fill, d[40:24]);
      compare("overflowed", e.ovf, d[41]);
      compare("load_rejected", e.rej, d[42]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  plant_checker sb;
  int cycle_count = 0;
  int hold_left = 0;
  int mode_left = 500;
  bit choppy = 1'b0;
  int burst_left = 0;

  tank_level_plant_step DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("tank_level_plant_step: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata[17:0], s_tdata[41:18]);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata);
    end
  end

  // receiver: alternates calm stretches with choppy ones of short and long stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (choppy && $urandom_range(0, 5) == 0)
        hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
    end
    mode_left--;
    if (mode_left <= 0) begin
      choppy = !choppy;
      mode_left = $urandom_range(100, 3000);
    end
  end

  task put_beat(logic load, logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] nl);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= load;
    s_tdata <= {6'b0, nl, cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  task idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task wait_drained();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_reg(tlps_cfg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
  endtask

  task set_plant(logic [23:0] h, logic [23:0] ih, logic [23:0] ib, logic [23:0] oa,
                 logic [23:0] pm, logic [9:0] tk);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_INV_HEIGHT, ih);
    write_reg(CFG_INV_AREA, ib);
    write_reg(CFG_OUTLET, oa);
    write_reg(CFG_PUMP, pm);
    write_reg(CFG_TICK, {14'b0, tk});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task sender_gap();
    if (burst_left == 0) begin
      idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(30, 300) : $urandom_range(1, 12));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    burst_left--;
  endtask

  // mostly ticks with in-range commands, some clamped ones, loads in and out of range
  task random_beat();
    logic [CMD_W-1:0] cmd;
    logic [LEVEL_W-1:0] nl;
    int pick;
    cmd = $urandom;
    nl = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      if (pick < 9) begin
        nl = (sb.height > 1) ? $urandom_range(1, sb.height - 1) : 24'd1;
      end else begin
        case ($urandom_range(0, 3))
          0: nl = '0;
          1: nl = sb.height;
          2: nl = 24'hFFFFFF;
          default: ;
        endcase
      end
      put_beat(1'b1, cmd, nl);
    end else begin
      if (pick < 60) cmd = $urandom_range(0, 65536);
      else if (pick < 70) cmd = ONE_Q16;
      else if (pick < 80) cmd = {1'b1, 17'($urandom)};
      put_beat(1'b0, cmd, nl);
    end
  endtask

  task random_phase(int n);
    for (int k = 0; k < n; k++) begin
      sender_gap();
      random_beat();
      if (k == n / 2 && $urandom_range(0, 1) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task random_config();
    logic [23:0] h, ih;
    longint unsigned recip;
    h = $urandom_range(2, 24'hFFFFFF);
    recip = 64'h1_0000_0000 / h;
    ih = (recip > 24'hFFFFFF) ? 24'hFFFFFF : recip[23:0];
    set_plant(h, ih, $urandom_range(1, 24'hFFFFFF), $urandom >> $urandom_range(8, 24),
              $urandom, $urandom_range(1, 1000));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: load bounds and command clamping
    put_beat(1'b0, 18'd0, 24'd0);
    put_beat(1'b1, 18'd0, 24'd0);
    put_beat(1'b1, 18'd0, 24'd65536);
    put_beat(1'b1, 18'h3FFFF, 24'hFFFFFF);
    put_beat(1'b1, 18'd0, 24'd1);
    put_beat(1'b0, 18'h20000, 24'hFFFFFF);
    put_beat(1'b1, 18'd0, 24'd65535);
    put_beat(1'b0, 18'h1FFFF, 24'd0);
    put_beat(1'b0, 18'd65536, 24'd0);
    put_beat(1'b0, 18'd65537, 24'd0);
    put_beat(1'b0, 18'd1, 24'd0);
    put_beat(1'b0, 18'h3FFFF, 24'd0);
    put_beat(1'b1, 18'd0, 24'h8000);
    wait_drained();

    // strong pump and outlet: drain to zero and overflow at the ceiling
    set_plant(24'h20000, 24'h8000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'd1000);
    put_beat(1'b1, 18'd0, 24'h1FFFF);
    put_beat(1'b0, 18'd0, 24'd0);
    put_beat(1'b0, 18'd65536, 24'd0);
    put_beat(1'b0, 18'd32768, 24'd0);
    put_beat(1'b0, 18'h3FFFB, 24'd0);
    put_beat(1'b1, 18'd0, 24'h20000);
    put_beat(1'b1, 18'd0, 24'h1FFFF);
    put_beat(1'b0, 18'd65536, 24'd0);
    wait_drained();

    set_plant(24'd327680, 24'd13107, 24'd32768, 24'd16777, 24'd8388608, 10'd100);
    random_phase(300);
    set_plant(24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'd1000);
    random_phase(200);
    set_plant(24'd1, 24'hFFFFFF, 24'd1, 24'd0, 24'd0, 10'd1);
    random_phase(80);
    repeat (3) begin
      random_config();
      random_phase(290);
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tank_level_plant_step: match");
    end else begin
      $display("tank_level_plant_step: mismatch");
    end
    $finish;
  end

endmodule
